### hdl/bgns_pkg.sv
// Shared constants and types for the binary grid neighbour stencil.
`timescale 1ns / 1ps

package bgns_pkg;

  // Largest row the line store can hold, and the widths that follow from it.
  localparam int MAX_WIDTH  = 256;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);

  // Field widths fixed by the interface.
  localparam int POS_W      = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int THR_W      = 4;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH      = 3'd0,
    REG_PASS_KIND      = 3'd1,
    REG_WALL_THRESHOLD = 3'd2,
    REG_LONE_COUNT     = 3'd3,
    REG_KEEP_THRESHOLD = 3'd4
  } cfg_reg_t;

  // Pass selection.
  localparam logic PASS_SMOOTH = 1'b0;
  localparam logic PASS_REMOVE = 1'b1;

  // Register values after reset.
  localparam logic [CFG_DATA_W-1:0] RST_ROW_WIDTH = CFG_DATA_W'(MAX_WIDTH);
  localparam logic [THR_W-1:0]      RST_WALL_THR  = 4'd5;
  localparam logic [THR_W-1:0]      RST_LONE_CNT  = 4'd1;
  localparam logic [THR_W-1:0]      RST_KEEP_THR  = 4'd5;

endpackage

### hdl/bgns_if.sv
// Valid/ready channel interfaces for the stencil input and result streams.
`timescale 1ns / 1ps

interface bgns_in_if;
  logic valid;
  logic ready;
  logic cell_wall;
  logic is_padding;
  logic frame_start;
  logic lone_chance;

  modport source (output valid, cell_wall, is_padding, frame_start, lone_chance,
                  input ready);
  modport sink   (input valid, cell_wall, is_padding, frame_start, lone_chance,
                  output ready);
endinterface

interface bgns_out_if;
  logic                       valid;
  logic                       ready;
  logic                       new_wall;
  logic [bgns_pkg::POS_W-1:0] out_row;
  logic [bgns_pkg::POS_W-1:0] out_col;

  modport source (output valid, new_wall, out_row, out_col, input ready);
  modport sink   (input valid, new_wall, out_row, out_col, output ready);
endinterface

### hdl/bgns_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bgns_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/binary_grid_neighbour_stencil.sv
// Top level of the streaming 3x3 wall-count stencil over a binary map.
`timescale 1ns / 1ps
// Throughput: one cell per clock while the result side does not hold off; the line store is
// read once and written once per beat. A cell's result leaves with the beat of the cell
// one row plus one column later, through stage one (line store read) and then the count
// into the output register.
// Reset (rst_n, synchronous, active low) clears position, warmup, pipeline valids and
// restores register defaults; the line store is not cleared, rows above row 0 are masked.

module binary_grid_neighbour_stencil (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bgns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgns_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  bgns_in_if.sink                             in_ch,
  bgns_out_if.source                          out_ch
);

  // Configuration registers.
  logic [bgns_pkg::CFG_DATA_W-1:0] row_width_r;
  logic                            pass_kind_r;
  logic [bgns_pkg::THR_W-1:0]      wall_thr_r;
  logic [bgns_pkg::THR_W-1:0]      lone_cnt_r;
  logic [bgns_pkg::THR_W-1:0]      keep_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= bgns_pkg::RST_ROW_WIDTH;
      pass_kind_r <= bgns_pkg::PASS_SMOOTH;
      wall_thr_r  <= bgns_pkg::RST_WALL_THR;
      lone_cnt_r  <= bgns_pkg::RST_LONE_CNT;
      keep_thr_r  <= bgns_pkg::RST_KEEP_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        bgns_pkg::REG_ROW_WIDTH:      row_width_r <= cfg_wdata;
        bgns_pkg::REG_PASS_KIND:      pass_kind_r <= cfg_wdata[0];
        bgns_pkg::REG_WALL_THRESHOLD: wall_thr_r  <= cfg_wdata[bgns_pkg::THR_W-1:0];
        bgns_pkg::REG_LONE_COUNT:     lone_cnt_r  <= cfg_wdata[bgns_pkg::THR_W-1:0];
        bgns_pkg::REG_KEEP_THRESHOLD: keep_thr_r  <= cfg_wdata[bgns_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row width: zero acts as one, anything above the store depth is clipped.
  logic [bgns_pkg::WIDTH_W-1:0] eff_width;

  always_comb begin
    if (row_width_r == '0) begin
      eff_width = bgns_pkg::WIDTH_W'(1);
    end else if (row_width_r > bgns_pkg::CFG_DATA_W'(bgns_pkg::MAX_WIDTH)) begin
      eff_width = bgns_pkg::WIDTH_W'(bgns_pkg::MAX_WIDTH);
    end else begin
      eff_width = bgns_pkg::WIDTH_W'(row_width_r);
    end
  end

  // Pipeline control.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_go;
  logic accept;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign accept      = in_ch.valid && in_ch.ready;

  // Input position and warmup; a frame start restarts them before the beat is used.
  logic [bgns_pkg::ADDR_W-1:0] in_col_r;
  logic [bgns_pkg::POS_W-1:0]  in_row_r;
  logic [1:0]                  warm_r;
  logic [bgns_pkg::ADDR_W-1:0] col_e;
  logic [bgns_pkg::POS_W-1:0]  row_e;
  logic [1:0]                  warm_e;
  logic                        row_end;

  always_comb begin
    col_e   = in_ch.frame_start ? '0 : in_col_r;
    row_e   = in_ch.frame_start ? '0 : in_row_r;
    warm_e  = in_ch.frame_start ? 2'd0 : warm_r;
    row_end = ({1'b0, col_e} + bgns_pkg::WIDTH_W'(1)) >= eff_width;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      warm_r   <= 2'd0;
    end else if (accept) begin
      if (row_end) begin
        in_col_r <= '0;
        in_row_r <= row_e + bgns_pkg::POS_W'(1);
        warm_r   <= (warm_e == 2'd2) ? 2'd2 : warm_e + 2'd1;
      end else begin
        in_col_r <= col_e + bgns_pkg::ADDR_W'(1);
        in_row_r <= row_e;
        warm_r   <= warm_e;
      end
    end
  end

  // Stage one holds the accepted beat while the line store read completes.
  logic [bgns_pkg::ADDR_W-1:0] s1_col_r;
  logic [bgns_pkg::POS_W-1:0]  s1_row_r;
  logic [1:0]                  s1_warm_r;
  logic                        s1_cell_r;
  logic                        s1_chance_r;
  logic                        fwd_r;
  logic [1:0]                  fwd_data_r;
  logic [1:0]                  ram_rdata;
  logic [1:0]                  stored;
  logic [1:0]                  wr_data;

  assign stored  = fwd_r ? fwd_data_r : ram_rdata;
  assign wr_data = {stored[0], s1_cell_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r    <= col_e;
      s1_row_r    <= row_e;
      s1_warm_r   <= warm_e;
      s1_cell_r   <= in_ch.cell_wall && !in_ch.is_padding;
      s1_chance_r <= in_ch.lone_chance;
      fwd_data_r  <= wr_data;
    end
  end

  // Forward the entry being written when the next beat reads the same column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= s1_go && (s1_col_r == col_e);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
    end
  end

  // Line store: bit 0 one row up, bit 1 two rows up, per column.
  bgns_ram #(
    .WIDTH (2),
    .DEPTH (bgns_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col_e),
    .rdata (ram_rdata)
  );

  // Window update, wall count and rule evaluation.
  logic [8:0]                  window_r;
  logic [8:0]                  window_nxt;
  logic [8:0]                  win;
  logic [3:0]                  count;
  logic                        emit;
  logic [bgns_pkg::POS_W-1:0]  ctr_col;
  logic [bgns_pkg::POS_W-1:0]  ctr_row;
  logic                        result;
  logic                        up1;
  logic                        up2;

  always_comb begin
    up1        = (s1_warm_r >= 2'd1) && stored[0];
    up2        = (s1_warm_r == 2'd2) && stored[1];
    window_nxt = {window_r[5:0], up2, up1, s1_cell_r};
    emit       = (s1_warm_r == 2'd2) || (s1_warm_r == 2'd1 && s1_col_r != '0);
    if (s1_col_r == '0) begin
      ctr_col = bgns_pkg::POS_W'(eff_width - bgns_pkg::WIDTH_W'(1));
      ctr_row = s1_row_r - bgns_pkg::POS_W'(2);
    end else begin
      ctr_col = bgns_pkg::POS_W'(s1_col_r - bgns_pkg::ADDR_W'(1));
      ctr_row = s1_row_r - bgns_pkg::POS_W'(1);
    end
    win = window_nxt;
    if (ctr_col == '0) begin
      win[8:6] = 3'b000;
    end
    if (({1'b0, ctr_col} + bgns_pkg::WIDTH_W'(1)) >= eff_width) begin
      win[2:0] = 3'b000;
    end
    count = '0;
    for (int i = 0; i < 9; i++) begin
      count = count + 4'(win[i]);
    end
    if (pass_kind_r == bgns_pkg::PASS_SMOOTH) begin
      result = (count >= wall_thr_r) || (count == lone_cnt_r && s1_chance_r);
    end else begin
      result = win[4] && (count > keep_thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_go) begin
      window_r <= window_nxt;
    end
  end

  // Output register.
  logic                       new_wall_r;
  logic [bgns_pkg::POS_W-1:0] out_row_r;
  logic [bgns_pkg::POS_W-1:0] out_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      new_wall_r <= result;
      out_row_r  <= ctr_row;
      out_col_r  <= ctr_col;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.new_wall = new_wall_r;
  assign out_ch.out_row  = out_row_r;
  assign out_ch.out_col  = out_col_r;

  // Checks on the pipeline control.
  a_no_emit_cold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_warm_r == 2'd0) |=> !out_valid_r)
    else $error("result produced before the first row was seen");

  a_fwd_live : assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forwarding flag set with no beat in stage one");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_fwd_same_col : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_go && s1_col_r == col_e) |=> fwd_r)
    else $error("same-column read not forwarded");

endmodule

### sim/tb_binary_grid_neighbour_stencil.sv
// Self-checking testbench for the streaming 3x3 wall-count stencil.
`timescale 1ns / 1ps

module tb_binary_grid_neighbour_stencil;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int END_WAIT_LIMIT   = 20000;
  localparam int LONG_HOLD_CYCLES = 300;

  // One updated cell as it leaves the block.
  typedef struct packed {
    logic                       new_wall;
    logic [bgns_pkg::POS_W-1:0] row;
    logic [bgns_pkg::POS_W-1:0] col;
  } cave_cell_t;

  // Register settings, kept in step with what has been written to the block.
  typedef struct packed {
    logic [bgns_pkg::CFG_DATA_W-1:0] row_width;
    logic                            pass_kind;
    logic [bgns_pkg::THR_W-1:0]      wall_thr;
    logic [bgns_pkg::THR_W-1:0]      lone_cnt;
    logic [bgns_pkg::THR_W-1:0]      keep_thr;
  } stencil_regs_t;

  // Ready patterns of the result side.
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE} sink_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bgns_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bgns_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bgns_in_if  in_ch ();
  bgns_out_if out_ch ();

  binary_grid_neighbour_stencil dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted state of the stencil: two stored rows per column, the window and position.
  stencil_regs_t regs = '{row_width: bgns_pkg::RST_ROW_WIDTH,
                          pass_kind: bgns_pkg::PASS_SMOOTH,
                          wall_thr: bgns_pkg::RST_WALL_THR,
                          lone_cnt: bgns_pkg::RST_LONE_CNT,
                          keep_thr: bgns_pkg::RST_KEEP_THR};
  logic [1:0]                 past_rows [bgns_pkg::MAX_WIDTH] = '{default: 2'b00};
  logic [8:0]                 window   = '0;
  int                         in_col   = 0;
  logic [bgns_pkg::POS_W-1:0] in_row   = '0;
  int                         warm_rows = 0;

  cave_cell_t pending_cells [$];
  int         errors = 0;
  int         beats_sent = 0;
  int         cells_checked = 0;
  int         settings_applied = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  bit         sender_steady = 1'b0;
  int         hold_requests = 0;

  function automatic int map_width();
    if (regs.row_width == 0) return 1;
    if (regs.row_width > bgns_pkg::MAX_WIDTH) return bgns_pkg::MAX_WIDTH;
    return int'(regs.row_width);
  endfunction

  // Takes one incoming cell and works out the updated cell it releases, if any.
  function automatic bit advance_stencil(input logic wall, input logic pad,
                                         input logic start, input logic chance,
                                         output cave_cell_t res);
    int                         w;
    int                         ccol;
    int                         walls;
    logic                       cur_wall;
    logic [1:0]                 stored;
    logic                       up1;
    logic                       up2;
    logic [8:0]                 win;
    logic [bgns_pkg::POS_W-1:0] crow;
    bit                         emit;
    w = map_width();
    if (start) begin
      in_col    = 0;
      in_row    = '0;
      warm_rows = 0;
    end
    cur_wall = wall & ~pad;
    stored   = past_rows[in_col];
    up1      = (warm_rows >= 1) ? stored[0] : 1'b0;
    up2      = (warm_rows >= 2) ? stored[1] : 1'b0;
    past_rows[in_col] = {stored[0], cur_wall};
    window = {window[5:0], up2, up1, cur_wall};
    emit   = (warm_rows >= 2) || (warm_rows == 1 && in_col >= 1);
    res    = '0;
    if (emit) begin
      if (in_col == 0) begin
        ccol = w - 1;
        crow = in_row - 8'd2;
      end else begin
        ccol = in_col - 1;
        crow = in_row - 8'd1;
      end
      // Columns left of the map and right of the last column count as open.
      win = window;
      if (ccol == 0) win[8:6] = 3'b000;
      if (ccol + 1 >= w) win[2:0] = 3'b000;
      walls = $countones(win);
      if (regs.pass_kind == bgns_pkg::PASS_SMOOTH) begin
        res.new_wall = (walls >= regs.wall_thr) || (walls == regs.lone_cnt && chance);
      end else begin
        res.new_wall = win[4] && (walls > regs.keep_thr);
      end
      res.row = crow;
      res.col = ccol[bgns_pkg::POS_W-1:0];
    end
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row = in_row + 8'd1;
      if (warm_rows < 2) warm_rows++;
    end else begin
      in_col++;
    end
    return emit;
  endfunction

  function automatic stencil_regs_t make_regs(input int w, input logic pass, input int wall_t,
                                              input int lone_c, input int keep_t);
    stencil_regs_t s;
    s.row_width = bgns_pkg::CFG_DATA_W'(w);
    s.pass_kind = pass;
    s.wall_thr  = bgns_pkg::THR_W'(wall_t);
    s.lone_cnt  = bgns_pkg::THR_W'(lone_c);
    s.keep_thr  = bgns_pkg::THR_W'(keep_t);
    return s;
  endfunction

  // Writes every register in turn; only called while the block is idle.
  task automatic apply_regs(input stencil_regs_t s);
    cfg_we    <= 1'b1;
    cfg_index <= bgns_pkg::REG_ROW_WIDTH;
    cfg_wdata <= s.row_width;
    @(posedge clk);
    cfg_index <= bgns_pkg::REG_PASS_KIND;
    cfg_wdata <= bgns_pkg::CFG_DATA_W'(s.pass_kind);
    @(posedge clk);
    cfg_index <= bgns_pkg::REG_WALL_THRESHOLD;
    cfg_wdata <= bgns_pkg::CFG_DATA_W'(s.wall_thr);
    @(posedge clk);
    cfg_index <= bgns_pkg::REG_LONE_COUNT;
    cfg_wdata <= bgns_pkg::CFG_DATA_W'(s.lone_cnt);
    @(posedge clk);
    cfg_index <= bgns_pkg::REG_KEEP_THRESHOLD;
    cfg_wdata <= bgns_pkg::CFG_DATA_W'(s.keep_thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = s;
    settings_applied++;
  endtask

  // Offers one cell beat, with bursts and gaps on the sending side, and predicts its result.
  task automatic send_cell(input logic wall, input logic pad, input logic start,
                           input logic chance);
    int         gap;
    cave_cell_t res;
    if (!sender_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.cell_wall   <= wall;
    in_ch.is_padding  <= pad;
    in_ch.frame_start <= start;
    in_ch.lone_chance <= chance;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (advance_stencil(wall, pad, start, chance, res)) pending_cells.push_back(res);
  endtask

  // A map of random cells, optionally padded; noisy maps add stray padding and restarts.
  task automatic send_map(input int n_cells, input int n_pad, input int density,
                          input bit noisy);
    int   i;
    logic start;
    logic pad;
    for (i = 0; i < n_cells + n_pad; i++) begin
      start = (i == 0) || (noisy && $urandom_range(0, 39) == 0);
      pad   = (i >= n_cells) || (noisy && $urandom_range(0, 19) == 0);
      send_cell($urandom_range(0, 99) < density, pad, start, $urandom_range(0, 1));
    end
  endtask

  // Stops sending and waits until every predicted cell has been seen.
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register defaults straight after reset, over full-width rows.
  task automatic test_reset_defaults();
    send_map(bgns_pkg::MAX_WIDTH + 3, 0, $urandom_range(35, 65), 1'b0);
    wait_for_idle();
  endtask

  // A solid 3x3 block reaches the highest count; padding walls must count as open.
  task automatic test_full_window();
    int i;
    apply_regs(make_regs(3, bgns_pkg::PASS_SMOOTH, 9, 15, 5));
    for (i = 0; i < 9; i++) send_cell(1'b1, 1'b0, i == 0, 1'b1);
    for (i = 0; i < 4; i++) send_cell(1'b1, 1'b1, 1'b0, 1'b1);
    wait_for_idle();
  endtask

  // Removal pass: walls with few neighbours open, crowded walls stay.
  task automatic test_removal_pass();
    int i;
    apply_regs(make_regs(2, bgns_pkg::PASS_REMOVE, 5, 1, 2));
    send_cell(1'b1, 1'b0, 1'b1, 1'b0);
    send_cell(1'b1, 1'b0, 1'b0, 1'b1);
    send_cell(1'b1, 1'b0, 1'b0, 1'b0);
    send_cell(1'b0, 1'b0, 1'b0, 1'b1);
    send_cell(1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(1'b1, 1'b0, 1'b0, 1'b1);
    for (i = 0; i < 3; i++) send_cell(1'b0, 1'b1, 1'b0, 1'b0);
    wait_for_idle();
  endtask

  // Lone count of zero with the chance bit, a wall threshold above nine, and a
  // restart in the middle of a frame.
  task automatic test_lone_chance_restart();
    apply_regs(make_regs(1, bgns_pkg::PASS_SMOOTH, 10, 0, 5));
    send_cell(1'b0, 1'b0, 1'b1, 1'b0);
    send_cell(1'b0, 1'b0, 1'b0, 1'b1);
    send_cell(1'b0, 1'b0, 1'b0, 1'b1);
    send_cell(1'b1, 1'b0, 1'b0, 1'b1);
    send_cell(1'b0, 1'b0, 1'b1, 1'b1);
    send_cell(1'b0, 1'b0, 1'b0, 1'b0);
    send_cell(1'b0, 1'b0, 1'b0, 1'b1);
    wait_for_idle();
  endtask

  // Width above the maximum acts as the maximum; width zero acts as one, and a
  // one-cell-wide map runs the row number past 255.
  task automatic test_width_limits();
    apply_regs(make_regs(300, bgns_pkg::PASS_REMOVE, 5, 1, 9));
    send_map(bgns_pkg::MAX_WIDTH + 2, 0, 50, 1'b0);
    wait_for_idle();
    apply_regs(make_regs(0, bgns_pkg::PASS_SMOOTH, 15, 3, 5));
    send_map(262, 0, 60, 1'b0);
    wait_for_idle();
  endtask

  // The result side holds off for a long stretch while cells keep coming.
  task automatic test_output_stall();
    apply_regs(make_regs(5, $urandom_range(0, 1), $urandom_range(2, 7), $urandom_range(0, 9),
                         $urandom_range(0, 9)));
    sender_steady = 1'b1;
    hold_requests <= hold_requests + 1;
    send_map(60, 6, 50, 1'b0);
    sender_steady = 1'b0;
    wait_for_idle();
  endtask

  // Fixed extreme then random settings, mostly narrow maps; most frames are flushed, some
  // are cut short and carry stray padding and restarts.
  task automatic test_random_maps();
    int            phase;
    int            phase_beats;
    int            w;
    int            rows;
    int            n_pad;
    bit            broken;
    stencil_regs_t s;
    for (phase = 0; phase < 6; phase++) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      case (phase)
        0: s = make_regs(w, bgns_pkg::PASS_SMOOTH, 0, 0, 0);
        1: s = make_regs(w, bgns_pkg::PASS_REMOVE, 15, 15, 15);
        2: s = make_regs(w, bgns_pkg::PASS_REMOVE, 9, 9, 0);
        default: begin
          s = make_regs(w, $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15));
          if ($urandom_range(0, 2) != 0) begin
            s.wall_thr = bgns_pkg::THR_W'($urandom_range(2, 7));
            s.lone_cnt = bgns_pkg::THR_W'($urandom_range(0, 9));
            s.keep_thr = bgns_pkg::THR_W'($urandom_range(0, 9));
          end
        end
      endcase
      apply_regs(s);
      phase_beats = 0;
      while (phase_beats < 40) begin
        rows = $urandom_range(1, 5);
        if (rows * w > 80) rows = 80 / w;
        broken = ($urandom_range(0, 3) == 0);
        n_pad  = broken ? $urandom_range(0, w) : w + 1;
        send_map(rows * w, n_pad, $urandom_range(5, 95), broken);
        phase_beats += rows * w + n_pad;
      end
      wait_for_idle();
    end
  endtask

  // Result side: ready follows a changing pattern, with a long hold when asked for.
  initial begin : result_sink
    int         served;
    int         stretch;
    sink_mode_t mode;
    served  = 0;
    stretch = 0;
    mode    = SINK_OPEN;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = sink_mode_t'($urandom_range(0, 2));
          stretch = $urandom_range(16, 96);
        end
        stretch--;
        case (mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= $urandom_range(0, 1);
          SINK_SPARSE: out_ch.ready <= (stretch % 4 == 0);
          default:     out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Every result beat is compared with the oldest predicted cell.
  always @(posedge clk) begin : check_results
    cave_cell_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected result beat: row %0d col %0d", out_ch.out_row, out_ch.out_col);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        cells_checked++;
        if (out_ch.new_wall !== want.new_wall) begin
          $error("new_wall: expected %0b, got %0b", want.new_wall, out_ch.new_wall);
          errors++;
        end
        if (out_ch.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
          errors++;
        end
        if (out_ch.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
          errors++;
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d cells still due", cycle_count,
               pending_cells.size());
      $display("tb_binary_grid_neighbour_stencil NOT OK");
      $finish;
    end
  end

  initial begin : run_tests
    int waited;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= bgns_pkg::REG_ROW_WIDTH;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cell_wall   <= 1'b0;
    in_ch.is_padding  <= 1'b0;
    in_ch.frame_start <= 1'b0;
    in_ch.lone_chance <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_full_window();
    test_removal_pass();
    test_lone_chance_restart();
    test_width_limits();
    test_output_stall();
    test_random_maps();

    // Final drain: anything still predicted after the wait is a loss.
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_cells.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_cells.size() != 0) begin
      $error("%0d predicted cells never left the block", pending_cells.size());
      errors++;
    end

    $display("Sent %0d cell beats and checked %0d updated cells under %0d register settings,",
             beats_sent, cells_checked, settings_applied + 1);
    $display("covering both passes, widths from zero to beyond the line store, and a long stall.");
    if (errors == 0) begin
      $display("tb_binary_grid_neighbour_stencil OK");
    end else begin
      $display("tb_binary_grid_neighbour_stencil NOT OK");
    end
    $finish;
  end

endmodule
